/* design/mst_pkg.sv */
// Shared types and constants for the multitouch slot tracker.
// Used by mst_frac and multitouch_slot_tracker_top; depends on nothing.
`default_nettype none

package mst_pkg;

   // Default sizes of the slot table and of the position fraction.
   localparam int SLOT_COUNT_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 16;

   // Event type codes.
   localparam logic [4:0] TYPE_SYNC = 5'd0;
   localparam logic [4:0] TYPE_ABS  = 5'd3;

   // Synchronization codes.
   localparam logic [9:0] SYNC_FRAME = 10'h000;
   localparam logic [9:0] SYNC_DROP  = 10'h003;

   // Absolute axis codes.
   localparam logic [9:0] ABS_SLOT     = 10'h02F;
   localparam logic [9:0] ABS_POS_X    = 10'h035;
   localparam logic [9:0] ABS_POS_Y    = 10'h036;
   localparam logic [9:0] ABS_TRACK_ID = 10'h039;

   // Request kind carried in tuser.
   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_LOST  = 1'b1;

   // Result phase.
   localparam logic PHASE_DOWN = 1'b0;
   localparam logic PHASE_UP   = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] REG_X_MIN = 2'd0;
   localparam logic [1:0] REG_X_MAX = 2'd1;
   localparam logic [1:0] REG_Y_MIN = 2'd2;
   localparam logic [1:0] REG_Y_MAX = 2'd3;

   // Saturation limit of the contact count.
   localparam logic [5:0] COUNT_MAX = 6'd63;

   // No contact / no primary.
   localparam logic signed [31:0] NO_ID = -32'sd1;

   // One slot table entry.
   typedef struct packed {
      logic signed [31:0] tracking_id;
      logic signed [31:0] ending_id;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      tracking_id: NO_ID,
      ending_id:   NO_ID,
      x:           32'sd0,
      y:           32'sd0
   };

endpackage

`default_nettype wire

/* design/mst_frac.sv */
// Bit-serial normalizer: maps a raw coordinate into a fraction of the span.
// Uses mst_pkg; one quotient bit per cycle by restoring division.
`default_nettype none

module mst_frac #(
   parameter int FRACTION_BITS = mst_pkg::FRACTION_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] raw,
   input  wire logic signed [31:0] lo,
   input  wire logic signed [31:0] hi,
   output logic                    busy,
   output logic [15:0]             frac
);
   import mst_pkg::*;

   localparam int NW = 33 + FRACTION_BITS;
   localparam int CW = $clog2(FRACTION_BITS);

   typedef enum logic [1:0] {F_IDLE, F_PREP, F_DIV} fstate_type;

   fstate_type                 state_ff;
   logic signed [32:0]         span_ff;
   logic signed [32:0]         d_ff;
   logic [32:0]                rem_ff;
   logic [FRACTION_BITS-1:0]   low_ff;
   logic [FRACTION_BITS-1:0]   quo_ff;
   logic [CW-1:0]              cnt_ff;

   logic [NW-1:0]              num;
   logic [33:0]                trial;
   logic [33:0]                trial_sub;
   logic [FRACTION_BITS+15:0]  quo_ext;

   // Numerator d * (2^FRACTION_BITS - 1) and the trial subtraction of one step.
   always_comb begin
      num       = {d_ff[32:0], {FRACTION_BITS{1'b0}}} - {{FRACTION_BITS{1'b0}}, d_ff[32:0]};
      trial     = {rem_ff, low_ff[FRACTION_BITS-1]};
      trial_sub = trial - {1'b0, span_ff[32:0]};
      quo_ext   = {16'd0, quo_ff};
   end

   assign busy = (state_ff != F_IDLE);
   assign frac = quo_ext[15:0];

   // Sequencer: take operands, settle the special cases, then divide.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (start) begin
                  span_ff  <= {hi[31], hi} - {lo[31], lo};
                  d_ff     <= {raw[31], raw} - {lo[31], lo};
                  state_ff <= F_PREP;
               end
            end
            F_PREP: begin
               if (span_ff <= 33'sd0 || d_ff <= 33'sd0) begin
                  quo_ff   <= '0;
                  state_ff <= F_IDLE;
               end else if (d_ff >= span_ff) begin
                  quo_ff   <= '1;
                  state_ff <= F_IDLE;
               end else begin
                  rem_ff   <= num[NW-1:FRACTION_BITS];
                  low_ff   <= num[FRACTION_BITS-1:0];
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               if (!trial_sub[33]) begin
                  rem_ff <= trial_sub[32:0];
                  quo_ff <= {quo_ff[FRACTION_BITS-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[32:0];
                  quo_ff <= {quo_ff[FRACTION_BITS-2:0], 1'b0};
               end
               low_ff <= {low_ff[FRACTION_BITS-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(FRACTION_BITS - 1)) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/multitouch_slot_tracker_top.sv */
// Top level of the multitouch slot tracker: slot table memory and sequencer.
// Uses mst_pkg and two mst_frac normalizers.
`default_nettype none

// Takes multitouch type B events, one per transfer, and reports contact downs
// and ups. Tracking-id and position events take a memory read and a write
// back; slot and other events are settled as they are taken. A release walks
// the slot table once and a frame report twice (downs, then ups); each
// reported contact waits for the bit-serial normalizers and for output
// back-pressure. A new transfer is taken only once the last event, its walk
// and the hand-over of its results are done. The table needs no clearing
// pass: per-slot valid flags reset it at once. The last result of an event
// is marked by rsp_tlast.
module multitouch_slot_tracker_top #(
   parameter int SLOT_COUNT    = mst_pkg::SLOT_COUNT_DEF,
   parameter int FRACTION_BITS = mst_pkg::FRACTION_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // event_type[4:0], event_code[14:5], event_value[46:15]
   input  wire logic [0:0]  req_tuser,  // op[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // contact_id[31:0], phase[32], position_x[48:33],
                                        // position_y[64:49]
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import mst_pkg::*;

   localparam int SW = $clog2(SLOT_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVENT, ST_SCAN, ST_EVAL, ST_NORM, ST_FIN, ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {PASS_DOWN, PASS_UP, PASS_REL} pass_type;

   // Control state.
   state_type               state_ff;
   pass_type                pass_ff;
   logic [SW-1:0]           idx_ff;
   logic [SW-1:0]           cur_ff;
   logic signed [31:0]      primary_ff;
   logic [5:0]              cnt_ff;
   logic                    discard_ff;
   logic                    drop_ff;
   logic [SLOT_COUNT-1:0]   began_ff;
   logic [SLOT_COUNT-1:0]   ended_ff;
   logic [SLOT_COUNT-1:0]   fwd_ff;
   logic [SLOT_COUNT-1:0]   valid_ff;
   logic signed [31:0]      xmin_ff;
   logic signed [31:0]      xmax_ff;
   logic signed [31:0]      ymin_ff;
   logic signed [31:0]      ymax_ff;
   logic                    hold_v_ff;
   logic                    rsp_valid_ff;

   // Payload registers.
   logic [9:0]              code_ff;
   logic signed [31:0]      value_ff;
   logic signed [31:0]      new_id_ff;
   logic                    new_phase_ff;
   logic signed [31:0]      hold_id_ff;
   logic                    hold_phase_ff;
   logic [15:0]             hold_x_ff;
   logic [15:0]             hold_y_ff;
   logic [71:0]             rsp_data_ff;
   logic                    rsp_last_ff;

   // Slot table memory.
   entry_type               mem [SLOT_COUNT];
   entry_type               q_ff;
   logic                    qv_ff;

   logic                    accept;
   logic                    in_op;
   logic [4:0]              in_type;
   logic [9:0]              in_code;
   logic signed [31:0]      in_value;
   logic [SW-1:0]           clamp_slot;
   entry_type               rd_entry;
   logic                    rd_en;
   logic [SW-1:0]           rd_addr;
   logic                    wr_en;
   logic [SW-1:0]           wr_addr;
   entry_type               wr_data;
   entry_type               ev_entry;
   logic                    ev_wr;
   logic                    ev_begin;
   logic                    ev_end;
   logic                    scan_hit;
   logic                    last_idx;
   state_type               adv_state;
   pass_type                adv_pass;
   logic [SW-1:0]           adv_idx;
   logic [5:0]              cnt_inc;
   logic                    down_primary;
   logic                    eval_emit;
   logic signed [31:0]      eval_id;
   logic                    eval_phase;
   logic                    out_free;
   logic                    rsp_load;
   logic                    frac_start;
   logic                    busy_x;
   logic                    busy_y;
   logic [15:0]             frac_x;
   logic [15:0]             frac_y;

   // Input field unpacking and slot clamping.
   always_comb begin
      in_op    = req_tuser[0];
      in_type  = req_tdata[4:0];
      in_code  = req_tdata[14:5];
      in_value = $signed(req_tdata[46:15]);
      if (in_value < 32'sd0) begin
         clamp_slot = '0;
      end else if (in_value > $signed(32'(SLOT_COUNT - 1))) begin
         clamp_slot = SW'(SLOT_COUNT - 1);
      end else begin
         clamp_slot = in_value[SW-1:0];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_entry   = qv_ff ? q_ff : ENTRY_RESET;
   assign last_idx   = (idx_ff == SW'(SLOT_COUNT - 1));

   // A parked result moves into the output register.
   assign rsp_load = hold_v_ff && out_free &&
                     ((state_ff == ST_NORM && !busy_x && !busy_y) || state_ff == ST_FLUSH);

   // Flag of the slot under the walk pointer for the current pass.
   always_comb begin
      unique case (pass_ff)
         PASS_DOWN: scan_hit = began_ff[idx_ff];
         PASS_UP:   scan_hit = ended_ff[idx_ff];
         PASS_REL:  scan_hit = fwd_ff[idx_ff];
         default:   scan_hit = 1'b0;
      endcase
   end

   // Next walk position.
   always_comb begin
      adv_pass = pass_ff;
      if (last_idx) begin
         adv_idx = '0;
         if (pass_ff == PASS_DOWN) begin
            adv_pass  = PASS_UP;
            adv_state = ST_SCAN;
         end else begin
            adv_state = ST_FIN;
         end
      end else begin
         adv_idx   = idx_ff + 1'b1;
         adv_state = ST_SCAN;
      end
   end

   // Event update of the current slot entry.
   always_comb begin
      ev_entry = rd_entry;
      ev_wr    = 1'b0;
      ev_begin = 1'b0;
      ev_end   = 1'b0;
      priority case (code_ff)
         ABS_TRACK_ID: begin
            if (value_ff >= 32'sd0) begin
               ev_entry.tracking_id = value_ff;
               ev_entry.ending_id   = NO_ID;
               ev_wr                = 1'b1;
               ev_begin             = 1'b1;
            end else if (rd_entry.tracking_id >= 32'sd0) begin
               ev_entry.ending_id   = rd_entry.tracking_id;
               ev_entry.tracking_id = NO_ID;
               ev_wr                = 1'b1;
               ev_end               = 1'b1;
            end
         end
         ABS_POS_X: begin
            ev_entry.x = value_ff;
            ev_wr      = 1'b1;
         end
         ABS_POS_Y: begin
            ev_entry.y = value_ff;
            ev_wr      = 1'b1;
         end
         default: ev_wr = 1'b0;
      endcase
   end

   // Per-slot decision during the walk.
   always_comb begin
      cnt_inc      = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 6'd1;
      down_primary = (primary_ff == NO_ID) && (cnt_inc == 6'd1);
      eval_emit    = 1'b0;
      eval_id      = rd_entry.tracking_id;
      eval_phase   = PHASE_DOWN;
      unique case (pass_ff)
         PASS_DOWN: begin
            eval_emit = !down_primary && (rd_entry.tracking_id != primary_ff);
         end
         PASS_UP: begin
            eval_emit  = fwd_ff[idx_ff];
            eval_id    = rd_entry.ending_id;
            eval_phase = PHASE_UP;
         end
         PASS_REL: begin
            eval_emit  = 1'b1;
            eval_id    = (rd_entry.tracking_id >= 32'sd0) ? rd_entry.tracking_id
                                                           : rd_entry.ending_id;
            eval_phase = PHASE_UP;
         end
         default: eval_emit = 1'b0;
      endcase
   end

   // Memory port control.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cur_ff;
      if (accept) begin
         rd_en = 1'b1;
      end else if (state_ff == ST_SCAN && scan_hit) begin
         rd_en   = 1'b1;
         rd_addr = idx_ff;
      end
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = ev_entry;
      if (state_ff == ST_EVENT) begin
         wr_en = ev_wr;
      end else if (state_ff == ST_EVAL && pass_ff == PASS_UP) begin
         wr_en             = 1'b1;
         wr_addr           = idx_ff;
         wr_data           = rd_entry;
         wr_data.ending_id = NO_ID;
      end
   end

   // Slot table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff  <= mem[rd_addr];
         qv_ff <= valid_ff[rd_addr];
      end
   end

   assign frac_start = (state_ff == ST_EVAL) && eval_emit;

   mst_frac #(.FRACTION_BITS(FRACTION_BITS)) u_frac_x (
      .clock (clock),
      .reset (reset),
      .start (frac_start),
      .raw   (rd_entry.x),
      .lo    (xmin_ff),
      .hi    (xmax_ff),
      .busy  (busy_x),
      .frac  (frac_x)
   );

   mst_frac #(.FRACTION_BITS(FRACTION_BITS)) u_frac_y (
      .clock (clock),
      .reset (reset),
      .start (frac_start),
      .raw   (rd_entry.y),
      .lo    (ymin_ff),
      .hi    (ymax_ff),
      .busy  (busy_y),
      .frac  (frac_y)
   );

   // Sequencer, configuration registers and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_DOWN;
         idx_ff       <= '0;
         cur_ff       <= '0;
         primary_ff   <= NO_ID;
         cnt_ff       <= '0;
         discard_ff   <= 1'b0;
         drop_ff      <= 1'b0;
         began_ff     <= '0;
         ended_ff     <= '0;
         fwd_ff       <= '0;
         valid_ff     <= '0;
         xmin_ff      <= 32'sd0;
         xmax_ff      <= 32'sd4095;
         ymin_ff      <= 32'sd0;
         ymax_ff      <= 32'sd4095;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_X_MIN: xmin_ff <= $signed(csr_wdata);
               REG_X_MAX: xmax_ff <= $signed(csr_wdata);
               REG_Y_MIN: ymin_ff <= $signed(csr_wdata);
               REG_Y_MAX: ymax_ff <= $signed(csr_wdata);
               default:   xmin_ff <= xmin_ff;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  code_ff  <= in_code;
                  value_ff <= in_value;
                  idx_ff   <= '0;
                  if (in_op == OP_LOST) begin
                     pass_ff  <= PASS_REL;
                     drop_ff  <= 1'b0;
                     state_ff <= ST_SCAN;
                  end else if (in_type == TYPE_SYNC && in_code == SYNC_DROP) begin
                     pass_ff  <= PASS_REL;
                     drop_ff  <= 1'b1;
                     state_ff <= ST_SCAN;
                  end else if (discard_ff) begin
                     if (in_type == TYPE_SYNC && in_code == SYNC_FRAME) begin
                        discard_ff <= 1'b0;
                     end
                  end else if (in_type == TYPE_ABS) begin
                     if (in_code == ABS_SLOT) begin
                        cur_ff <= clamp_slot;
                     end else if (in_code == ABS_TRACK_ID || in_code == ABS_POS_X ||
                                  in_code == ABS_POS_Y) begin
                        state_ff <= ST_EVENT;
                     end
                  end else if (in_type == TYPE_SYNC && in_code == SYNC_FRAME) begin
                     pass_ff  <= PASS_DOWN;
                     state_ff <= ST_SCAN;
                  end
               end
            end

            // Write back the updated slot entry and its flags.
            ST_EVENT: begin
               if (ev_wr) begin
                  valid_ff[cur_ff] <= 1'b1;
               end
               if (ev_begin) begin
                  began_ff[cur_ff] <= 1'b1;
                  ended_ff[cur_ff] <= 1'b0;
               end
               if (ev_end) begin
                  ended_ff[cur_ff] <= 1'b1;
                  began_ff[cur_ff] <= 1'b0;
               end
               state_ff <= ST_IDLE;
            end

            ST_SCAN: begin
               if (scan_hit) begin
                  state_ff <= ST_EVAL;
               end else begin
                  state_ff <= adv_state;
                  pass_ff  <= adv_pass;
                  idx_ff   <= adv_idx;
               end
            end

            // Slot data is available: update gesture state, maybe report.
            ST_EVAL: begin
               if (pass_ff == PASS_DOWN) begin
                  cnt_ff           <= cnt_inc;
                  began_ff[idx_ff] <= 1'b0;
                  if (down_primary) begin
                     primary_ff <= rd_entry.tracking_id;
                  end else if (eval_emit) begin
                     fwd_ff[idx_ff] <= 1'b1;
                  end
               end else if (pass_ff == PASS_UP) begin
                  fwd_ff[idx_ff]   <= 1'b0;
                  ended_ff[idx_ff] <= 1'b0;
                  valid_ff[idx_ff] <= 1'b1;
                  if (cnt_ff != 6'd0) begin
                     cnt_ff <= cnt_ff - 6'd1;
                  end
               end
               if (eval_emit) begin
                  new_id_ff    <= eval_id;
                  new_phase_ff <= eval_phase;
                  state_ff     <= ST_NORM;
               end else begin
                  state_ff <= adv_state;
                  pass_ff  <= adv_pass;
                  idx_ff   <= adv_idx;
               end
            end

            // Wait for the positions, then park the result; an older parked
            // result moves to the output first, known not to be the last.
            ST_NORM: begin
               if (!busy_x && !busy_y && (!hold_v_ff || out_free)) begin
                  if (hold_v_ff) begin
                     rsp_data_ff <= {7'd0, hold_y_ff, hold_x_ff, hold_phase_ff, hold_id_ff};
                     rsp_last_ff <= 1'b0;
                  end
                  hold_v_ff     <= 1'b1;
                  hold_id_ff    <= new_id_ff;
                  hold_phase_ff <= new_phase_ff;
                  hold_x_ff     <= frac_x;
                  hold_y_ff     <= frac_y;
                  state_ff      <= adv_state;
                  pass_ff       <= adv_pass;
                  idx_ff        <= adv_idx;
               end
            end

            ST_FIN: begin
               if (pass_ff == PASS_REL) begin
                  valid_ff   <= '0;
                  began_ff   <= '0;
                  ended_ff   <= '0;
                  fwd_ff     <= '0;
                  primary_ff <= NO_ID;
                  cnt_ff     <= '0;
                  if (drop_ff) begin
                     discard_ff <= 1'b1;
                  end
               end else if (cnt_ff == 6'd0) begin
                  primary_ff <= NO_ID;
               end
               state_ff <= ST_FLUSH;
            end

            // The parked result is the last one of this transfer.
            ST_FLUSH: begin
               if (!hold_v_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_data_ff <= {7'd0, hold_y_ff, hold_x_ff, hold_phase_ff, hold_id_ff};
                  rsp_last_ff <= 1'b1;
                  hold_v_ff   <= 1'b0;
                  state_ff    <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // Nothing stays parked once an event is finished.
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_v_ff)
      else $error("result left parked while idle");

   // The normalizers are done before the next event is taken.
   a_idle_no_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !busy_x && !busy_y)
      else $error("normalizer busy while idle");

   // With no contacts in the gesture there is no primary.
   a_primary_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cnt_ff == 6'd0) |-> primary_ff == NO_ID)
      else $error("primary kept with empty gesture");
`endif

endmodule

`default_nettype wire
